@@ sv/spq_pkg.sv @@
// Package with the types and constants shared by the sorted priority queue.
`timescale 1ns / 1ps

package spq_pkg;

   localparam int CAPACITY      = 16;
   localparam int COUNT_W       = $clog2(CAPACITY + 1);
   localparam int VALUE_W       = 32;
   localparam int PRIORITY_W    = 16;
   localparam int ENTRY_COUNT_W = 5;

   localparam logic signed [VALUE_W-1:0] EMPTY_VALUE = -32'sd1;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_REMOVE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic                         op;
      logic signed [VALUE_W-1:0]    item_value;
      logic signed [PRIORITY_W-1:0] item_priority;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] out_value;
      logic [1:0]                status;
      logic [ENTRY_COUNT_W-1:0]  entry_count;
      logic                      is_empty;
   } rsp_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0]    value;
      logic signed [PRIORITY_W-1:0] prio;
   } entry_type;

   typedef struct packed {
      logic      ins;
      logic      rem;
      entry_type fresh;
   } cell_cmd_type;

endpackage

@@ sv/spq_cell.sv @@
// One slot of the sorted chain: holds an entry and shifts with its neighbors.
`timescale 1ns / 1ps

module spq_cell (
   input  logic                  clock,
   input  spq_pkg::cell_cmd_type cmd_i,
   input  logic                  occupied_i,
   input  logic                  left_keep_i,
   input  spq_pkg::entry_type    left_entry_i,
   input  spq_pkg::entry_type    right_entry_i,
   output logic                  keep_o,
   output spq_pkg::entry_type    entry_o
);
   import spq_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   // A cell keeps its entry on an insert when it ranks at or above the new one.
   assign keep_o  = occupied_i && (entry_ff.prio >= cmd_i.fresh.prio);
   assign entry_o = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (cmd_i.ins && !keep_o) begin
         entry_in = left_keep_i ? cmd_i.fresh : left_entry_i;
      end else if (cmd_i.rem) begin
         entry_in = right_entry_i;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

@@ sv/sorted_priority_queue_unit.sv @@
// Top level of the sorted priority queue: a chain of slot cells and the result register.
`timescale 1ns / 1ps

// The queue holds up to CAPACITY entries sorted by priority, highest first, in a row
// of slot cells that compare against the incoming priority all at once and shift
// together. busy stays low, so a new beat can start in every cycle; its result appears
// on rsp_data with rsp_strobe high in the cycle after the start beat and must be
// taken in that cycle, since the receiver cannot hold it off. Equal priorities leave
// in arrival order, a remove from an empty queue returns -1, and an insert into a full
// queue is dropped with a full status.
module sorted_priority_queue_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  spq_pkg::req_type req_data,
   output logic             rsp_strobe,
   output spq_pkg::rsp_type rsp_data
);
   import spq_pkg::*;

   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic               rsp_strobe_ff;
   logic               rsp_strobe_in;
   rsp_type            rsp_ff;
   rsp_type            rsp_in;

   logic               accept;
   logic               is_full;
   logic               is_none;
   cell_cmd_type       cmd;
   logic               keep   [CAPACITY];
   entry_type          entries[CAPACITY];

   assign busy    = 1'b0;
   assign accept  = start && !busy;
   assign is_full = (count_ff == COUNT_W'(CAPACITY));
   assign is_none = (count_ff == '0);

   always_comb begin
      cmd.ins                = accept && (req_data.op == OP_INSERT) && !is_full;
      cmd.rem                = accept && (req_data.op == OP_REMOVE) && !is_none;
      cmd.fresh.value        = req_data.item_value;
      cmd.fresh.prio         = req_data.item_priority;
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic      left_keep;
      entry_type left_entry;
      entry_type right_entry;

      if (i == 0) begin : g_head
         assign left_keep  = 1'b1;
         assign left_entry = entries[i];
      end else begin : g_body
         assign left_keep  = keep[i-1];
         assign left_entry = entries[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign right_entry = entries[i];
      end else begin : g_mid
         assign right_entry = entries[i+1];
      end

      spq_cell u_cell (
         .clock        (clock),
         .cmd_i        (cmd),
         .occupied_i   (count_ff > COUNT_W'(i)),
         .left_keep_i  (left_keep),
         .left_entry_i (left_entry),
         .right_entry_i(right_entry),
         .keep_o       (keep[i]),
         .entry_o      (entries[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.ins) begin
         count_in = count_ff + COUNT_W'(1);
      end else if (cmd.rem) begin
         count_in = count_ff - COUNT_W'(1);
      end

      rsp_strobe_in = accept;

      rsp_in             = rsp_ff;
      rsp_in.out_value   = '0;
      rsp_in.status      = ST_OK;
      rsp_in.entry_count = ENTRY_COUNT_W'(count_in);
      rsp_in.is_empty    = (count_in == '0);
      case (req_data.op)
         OP_INSERT: begin
            if (is_full) begin
               rsp_in.status = ST_FULL;
            end
         end
         OP_REMOVE: begin
            if (is_none) begin
               rsp_in.out_value = EMPTY_VALUE;
               rsp_in.status    = ST_EMPTY;
            end else begin
               rsp_in.out_value = entries[0].value;
            end
         end
         default: begin
            rsp_in.status = ST_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(CAPACITY))
      else $error("entry count exceeds capacity");

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_strobe)
      else $error("accepted beat produced no result");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_data.is_empty == (count_ff == '0)))
      else $error("empty flag disagrees with stored count");

   a_full_drop: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.status == ST_FULL) |-> $stable(count_ff))
      else $error("dropped insert changed the count");

endmodule

@@ verif/sorted_priority_queue_unit_tb.sv @@
// Self-checking testbench for the sorted priority queue: directed table, then random traffic.
`timescale 1ns / 1ps

module sorted_priority_queue_unit_tb;

   import spq_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int PHASE_ITEMS  = 350;
   localparam int PLAN_ROWS    = 13;
   localparam int DRAIN_CYCLES = 4;

   typedef struct {
      op_type                       op;
      logic signed [VALUE_W-1:0]    value;
      logic signed [PRIORITY_W-1:0] prio;
      int                           reps;
      bit                           typed;
      rsp_type                      want;
   } plan_row;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;

   logic signed [VALUE_W-1:0]    shadow_value [CAPACITY];
   logic signed [PRIORITY_W-1:0] shadow_priority [CAPACITY];
   int                           shadow_fill;

   rsp_type pending_rsp [$];
   rsp_type oldest_rsp;
   int      fail_count;
   int      cycle_count;
   plan_row directed_plan [PLAN_ROWS];

   sorted_priority_queue_unit dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Applies one accepted beat to the shadow queue and returns the result it must produce.
   function automatic rsp_type queue_after_beat(req_type r);
      rsp_type res;
      int      pos;
      int      i;
      res.out_value = '0;
      res.status    = ST_OK;
      if (r.op == OP_INSERT) begin
         if (shadow_fill >= CAPACITY) begin
            res.status = ST_FULL;
         end else begin
            pos = 0;
            while (pos < shadow_fill && shadow_priority[pos] >= r.item_priority) pos++;
            for (i = shadow_fill; i > pos; i--) begin
               shadow_value[i]    = shadow_value[i-1];
               shadow_priority[i] = shadow_priority[i-1];
            end
            shadow_value[pos]    = r.item_value;
            shadow_priority[pos] = r.item_priority;
            shadow_fill++;
         end
      end else begin
         if (shadow_fill == 0) begin
            res.out_value = EMPTY_VALUE;
            res.status    = ST_EMPTY;
         end else begin
            res.out_value = shadow_value[0];
            for (i = 1; i < shadow_fill; i++) begin
               shadow_value[i-1]    = shadow_value[i];
               shadow_priority[i-1] = shadow_priority[i];
            end
            shadow_fill--;
         end
      end
      res.entry_count = shadow_fill[ENTRY_COUNT_W-1:0];
      res.is_empty    = (shadow_fill == 0);
      return res;
   endfunction

   // Holds start high until the beat is taken, then records the result it must produce.
   task automatic send_beat(input req_type r, input bit typed, input rsp_type typed_rsp);
      rsp_type predicted;
      start    <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      predicted = queue_after_beat(r);
      pending_rsp.push_back(typed ? typed_rsp : predicted);
   endtask

   task automatic sender_gap(input int idle_pct);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (pending_rsp.size() == 0) begin
            if (fail_count < 10) begin
               $display("unexpected result: value %0d status %0d count %0d empty %0d",
                        rsp_data.out_value, rsp_data.status, rsp_data.entry_count,
                        rsp_data.is_empty);
            end
            fail_count++;
         end else begin
            oldest_rsp = pending_rsp.pop_front();
            if (rsp_data.out_value !== oldest_rsp.out_value ||
                rsp_data.status !== oldest_rsp.status ||
                rsp_data.entry_count !== oldest_rsp.entry_count ||
                rsp_data.is_empty !== oldest_rsp.is_empty) begin
               if (fail_count < 10) begin
                  $display("mismatch: expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
                           oldest_rsp.out_value, oldest_rsp.status, oldest_rsp.entry_count,
                           oldest_rsp.is_empty, rsp_data.out_value, rsp_data.status,
                           rsp_data.entry_count, rsp_data.is_empty);
               end
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("sorted_priority_queue_unit_tb failed");
         $finish;
      end
   end

   initial begin
      req_type r;
      int      idle_pct [4];
      int      burst_left;
      int      insert_pct;
      int      row;
      int      k;
      int      phase;
      int      n;

      reset       = 1'b1;
      start       = 1'b0;
      req_data    = '0;
      shadow_fill = 0;
      idle_pct    = '{0, 49, 0, 19};

      directed_plan[0]  = '{OP_REMOVE, 32'sd0, 16'sd0, 1, 1'b1,
                            '{EMPTY_VALUE, ST_EMPTY, 5'd0, 1'b1}};
      directed_plan[1]  = '{OP_INSERT, 32'sh7fffffff, 16'sh7fff, 1, 1'b1,
                            '{32'sd0, ST_OK, 5'd1, 1'b0}};
      directed_plan[2]  = '{OP_INSERT, 32'sh80000000, 16'sh8000, 1, 1'b1,
                            '{32'sd0, ST_OK, 5'd2, 1'b0}};
      directed_plan[3]  = '{OP_INSERT, 32'sd0, 16'sd0, 1, 1'b0, '0};
      directed_plan[4]  = '{OP_INSERT, 32'sd5, 16'sd0, 1, 1'b0, '0};
      directed_plan[5]  = '{OP_INSERT, -32'sd1, 16'sh7fff, 1, 1'b0, '0};
      directed_plan[6]  = '{OP_REMOVE, 32'sh7fffffff, 16'sh7fff, 4, 1'b0, '0};
      directed_plan[7]  = '{OP_REMOVE, 32'sd0, 16'sd0, 1, 1'b0, '0};
      directed_plan[8]  = '{OP_REMOVE, 32'sd0, 16'sd0, 1, 1'b1,
                            '{EMPTY_VALUE, ST_EMPTY, 5'd0, 1'b1}};
      directed_plan[9]  = '{OP_INSERT, 32'sd100, 16'sd3, CAPACITY, 1'b0, '0};
      directed_plan[10] = '{OP_INSERT, 32'sd1, 16'sh7fff, 1, 1'b1,
                            '{32'sd0, ST_FULL, 5'd16, 1'b0}};
      directed_plan[11] = '{OP_REMOVE, 32'sd0, 16'sd0, CAPACITY, 1'b0, '0};
      directed_plan[12] = '{OP_REMOVE, 32'sd0, 16'sd0, 1, 1'b1,
                            '{EMPTY_VALUE, ST_EMPTY, 5'd0, 1'b1}};

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (row = 0; row < PLAN_ROWS; row++) begin
         for (k = 0; k < directed_plan[row].reps; k++) begin
            r.op            = directed_plan[row].op;
            r.item_value    = directed_plan[row].value + k;
            r.item_priority = directed_plan[row].prio;
            send_beat(r, directed_plan[row].typed, directed_plan[row].want);
         end
      end

      for (phase = 0; phase < 4; phase++) begin
         burst_left = 0;
         insert_pct = 50;
         for (n = 0; n < PHASE_ITEMS; n++) begin
            if (burst_left == 0) begin
               burst_left = $urandom_range(10, 40);
               case ($urandom_range(2))
                  0: begin
                     insert_pct = 15;
                  end
                  1: begin
                     insert_pct = 50;
                  end
                  default: begin
                     insert_pct = 85;
                  end
               endcase
            end
            burst_left--;
            r.op         = ($urandom_range(99) < insert_pct) ? OP_INSERT : OP_REMOVE;
            r.item_value = $urandom;
            if ($urandom_range(99) < 70) begin
               r.item_priority = PRIORITY_W'($signed($urandom_range(7)) - 4);
            end else begin
               r.item_priority = PRIORITY_W'($urandom);
            end
            sender_gap(idle_pct[phase]);
            send_beat(r, 1'b0, '0);
         end
      end

      start <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("sorted_priority_queue_unit_tb passed");
      end else begin
         $display("sorted_priority_queue_unit_tb failed");
      end
      $finish;
   end

endmodule
